### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the sine wave color palette unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset
`define SWCP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Expression that must never be true outside reset
`define SWCP_NEVER(label, expr, msg) \
    `SWCP_ASSERT(label, !(expr), msg)

`endif

### hw/rtl/swcp_pkg.sv
// ---------------------------------------------------------------------------
// Sine wave color palette package
// Widths, register indexes and sine table build constants.
// ---------------------------------------------------------------------------
package swcp_pkg;

    localparam int ANGLE_WIDTH      = 24;
    localparam int ANGLE_FRAC_BITS  = 16;
    localparam int WORD_WIDTH       = 48;
    localparam int LEVEL_WIDTH      = 8;
    localparam int NUM_CH           = 3;
    localparam int CFG_INDEX_WIDTH  = 2;

    // Quarter-wave table: depth is a power of two, 64 .. 16384
    localparam int SINE_ADDR_BITS   = 10;
    localparam int SINE_TABLE_DEPTH = 1 << SINE_ADDR_BITS;
    localparam int SINE_WIDTH       = 16;

    localparam int PROD_WIDTH       = ANGLE_WIDTH + 16;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_RED   = 2'd0,
        CFG_GREEN = 2'd1,
        CFG_BLUE  = 2'd2
    } t_cfg_index;

    // Table build sequence steps
    localparam logic [2:0] FILL_STEP_SQUARE = 3'd0;
    localparam logic [2:0] FILL_STEP_SINE   = 3'd6;
    localparam logic [2:0] FILL_STEP_WRITE  = 3'd7;

    localparam logic signed [32:0] POLY_SEED = -33'sd3864;

    // 127.5 * 2^30 expressed as 255 * 2^29
    localparam logic signed [41:0] LEVEL_BIAS = 42'sd136902082560;

    function automatic logic signed [32:0] poly_coef(input logic [2:0] step);
        logic signed [32:0] c;
        case (step)
            3'd1:    c = 33'sd172272;
            3'd2:    c = -33'sd5026995;
            3'd3:    c = 33'sd85569306;
            3'd4:    c = -33'sd693598670;
            3'd5:    c = 33'sd1686629713;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/sine_wave_color_palette_unit.sv
// Throughput is one item per cycle unless the output stalls or the sine tables are being built.
// Stages: period multiply, sine table read, amplitude multiply, level saturate.
// Reset clears the wave registers to 0 and rebuilds the quarter-wave sine tables
// through one shared multiplier, entry by entry (square, polynomial, sine, write steps),
// during which no item is accepted. Config writes always land.
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// Sine wave color palette unit
// Maps a pixel angle in turns to red, green and blue levels, one sine wave
// per channel with configurable period, phase and amplitude.
// ---------------------------------------------------------------------------
module sine_wave_color_palette_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [swcp_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [swcp_pkg::WORD_WIDTH-1:0]       i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [swcp_pkg::ANGLE_WIDTH-1:0]      i_angle_turns,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [swcp_pkg::LEVEL_WIDTH-1:0]      o_red_level,
    output logic [swcp_pkg::LEVEL_WIDTH-1:0]      o_green_level,
    output logic [swcp_pkg::LEVEL_WIDTH-1:0]      o_blue_level
);

    import swcp_pkg::*;

    // Wave registers
    logic [WORD_WIDTH-1:0] r_wave_word [NUM_CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_wave_word[c] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RED:   r_wave_word[0] <= i_cfg_data;
                CFG_GREEN: r_wave_word[1] <= i_cfg_data;
                CFG_BLUE:  r_wave_word[2] <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // Sine table build
    logic                      r_fill_busy;
    logic [SINE_ADDR_BITS-1:0] r_fill_idx;
    logic [2:0]                r_fill_step;
    logic signed [32:0]        r_s;
    logic [29:0]               r_u2;

    logic [29:0]               fill_u;
    logic signed [32:0]        mul_a;
    logic signed [31:0]        mul_b;
    logic signed [64:0]        fill_prod;
    logic signed [64:0]        fill_adj;
    logic signed [64:0]        fill_trunc;
    logic [17:0]               fill_round;
    logic [SINE_WIDTH-1:0]     fill_entry;
    logic                      fill_we;
    logic                      fill_done;

    always_comb begin
        fill_u = 30'({r_fill_idx, 1'b1}) << (29 - SINE_ADDR_BITS);
        mul_a  = (r_fill_step == FILL_STEP_SQUARE) ? $signed({3'b000, fill_u}) : r_s;
        mul_b  = (r_fill_step == FILL_STEP_SQUARE || r_fill_step == FILL_STEP_SINE)
               ? $signed({2'b00, fill_u}) : $signed({2'b00, r_u2});
        fill_prod  = 65'(mul_a) * 65'(mul_b);
        // Divide by 2^30 rounding toward zero
        fill_adj   = fill_prod + (fill_prod[64] ? 65'sd1073741823 : 65'sd0);
        fill_trunc = fill_adj >>> 30;
        fill_round = 18'(({1'b0, r_s[31:0]} + 33'd16384) >> 15);
        if (r_s[32]) begin
            fill_entry = '0;
        end else if (fill_round > 18'd32768) begin
            fill_entry = 16'd32768;
        end else begin
            fill_entry = fill_round[SINE_WIDTH-1:0];
        end
        fill_we   = r_fill_busy && (r_fill_step == FILL_STEP_WRITE);
        fill_done = fill_we && (r_fill_idx == SINE_ADDR_BITS'(SINE_TABLE_DEPTH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_busy <= 1'b1;
            r_fill_idx  <= '0;
            r_fill_step <= FILL_STEP_SQUARE;
        end else if (r_fill_busy) begin
            r_fill_step <= r_fill_step + 3'd1;
            if (r_fill_step == FILL_STEP_WRITE) begin
                r_fill_idx <= r_fill_idx + SINE_ADDR_BITS'(1);
                if (r_fill_idx == SINE_ADDR_BITS'(SINE_TABLE_DEPTH - 1)) begin
                    r_fill_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_fill_step)
            FILL_STEP_SQUARE: begin
                r_u2 <= fill_trunc[29:0];
                r_s  <= POLY_SEED;
            end
            FILL_STEP_SINE:  r_s <= fill_trunc[32:0];
            FILL_STEP_WRITE: r_s <= r_s;
            default:         r_s <= poly_coef(r_fill_step) + fill_trunc[32:0];
        endcase
    end

    // Pipeline flow control
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;
    logic in_accept;

    always_comb begin
        en4 = !r_v4 || i_out_ready;
        en3 = !r_v3 || en4;
        en2 = !r_v2 || en3;
        en1 = !r_v1 || en2;
        in_accept = i_in_valid && o_in_ready;
    end

    assign o_in_ready  = en1 && !r_fill_busy;
    assign o_out_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= in_accept;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // Channel lanes
    logic [LEVEL_WIDTH-1:0] r_level [NUM_CH];

    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
        logic [PROD_WIDTH-1:0]     r_prod;
        logic                      r_neg1;
        logic [SINE_WIDTH-1:0]     rom_data;
        logic signed [33:0]        r_as;
        logic [15:0]               turn;
        logic [SINE_ADDR_BITS-1:0] offs;
        logic [SINE_ADDR_BITS-1:0] raddr;
        logic signed [16:0]        sine;
        logic signed [33:0]        amp_sine;
        logic signed [41:0]        lvl_n;

        always_comb begin
            turn  = r_prod[ANGLE_FRAC_BITS-8 +: 16] + r_wave_word[ch][15:0];
            offs  = turn[13 -: SINE_ADDR_BITS];
            raddr = turn[14] ? ~offs : offs;
            sine  = r_neg1 ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
            amp_sine = 34'($signed({1'b0, r_wave_word[ch][47:32]})) * 34'(sine);
            lvl_n = (42'(r_as) <<< 8) - 42'(r_as) + LEVEL_BIAS;
        end

        always_ff @(posedge i_clk) begin
            if (en1) begin
                r_prod <= PROD_WIDTH'(i_angle_turns) * PROD_WIDTH'(r_wave_word[ch][31:16]);
            end
            if (en2) begin
                r_neg1 <= turn[15];
            end
            if (en3) begin
                r_as <= amp_sine;
            end
            if (en4) begin
                if (lvl_n <= 42'sd0) begin
                    r_level[ch] <= '0;
                end else if (lvl_n[41:30] > 12'd255) begin
                    r_level[ch] <= '1;
                end else begin
                    r_level[ch] <= lvl_n[37:30];
                end
            end
        end

        swcp_ram #(
            .WIDTH (SINE_WIDTH),
            .DEPTH (SINE_TABLE_DEPTH)
        ) u_sine_rom (
            .i_clk   (i_clk),
            .i_we    (fill_we),
            .i_waddr (r_fill_idx),
            .i_wdata (fill_entry),
            .i_re    (en2),
            .i_raddr (raddr),
            .o_rdata (rom_data)
        );
    end

    assign o_red_level   = r_level[0];
    assign o_green_level = r_level[1];
    assign o_blue_level  = r_level[2];

    `SWCP_ASSERT(a_fill_ends_last, $fell(r_fill_busy) |-> $past(fill_done), "table build ended early")
    `SWCP_NEVER(a_pipe_empty_fill, r_fill_busy && (r_v1 || r_v2 || r_v3 || r_v4), "item during fill")
    `SWCP_ASSERT(a_out_from_stage3, $rose(r_v4) |-> $past(r_v3), "result without a stage 3 item")

endmodule

### hw/rtl/swcp_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ---------------------------------------------------------------------------
module swcp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
